// ----- design/gda_pkg.sv -----
// Shared types, constants and calendar functions for the Gregorian date adder.
package gda_pkg;

  localparam int unsigned YEAR_W  = 16;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned MODE_W  = 3;
  localparam int unsigned COUNT_W = 10;
  localparam int unsigned DOY_W   = 9;
  localparam int unsigned STEPS_W = 17;  // 1023 * 120 fits
  localparam int unsigned M25_W   = 5;
  localparam int unsigned QUO_W   = 12;  // 65535 / 25 fits

  // floor(y * RECIP25 / 2^16) is y/25 or one less for any 16-bit y
  localparam logic [QUO_W-1:0] RECIP25 = 12'd2621;
  localparam logic [M25_W-1:0] MOD25_TOP = 5'd24;

  localparam logic [MODE_W-1:0] MODE_DAY    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_WEEK   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_MONTH  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_YEAR   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_DECADE = 3'd4;

  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_MOD,
    ST_CHECK,
    ST_RUN,
    ST_DONE
  } gda_state_e;

  typedef struct packed {
    logic load;    // capture request fields
    logic calc_q;  // register year / 25 estimate
    logic calc_r;  // register year mod 25
    logic arm;     // latch validity, load step counter
    logic step;    // one day or month step
  } gda_cmd_t;

  typedef struct packed {
    logic bad;       // start date impossible
    logic no_steps;  // nothing to iterate
    logic last;      // this step is the final one
  } gda_sts_t;

  // leap: divisible by 4, and not by 25 unless also by 16
  function automatic logic gda_leap(logic [YEAR_W-1:0] y, logic [M25_W-1:0] m25);
    return (y[1:0] == 2'd0) && ((m25 != '0) || (y[3:0] == 4'd0));
  endfunction

  function automatic logic [DAY_W-1:0] gda_month_len(logic [MONTH_W-1:0] m, logic leap);
    logic [DAY_W-1:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:    len = leap ? 5'd29 : 5'd28;
      default: len = 5'd0;
    endcase
    return len;
  endfunction

  // days before the first of month m in a common year
  function automatic logic [DOY_W-1:0] gda_days_before(logic [MONTH_W-1:0] m);
    logic [DOY_W-1:0] sum;
    case (m)
      4'd1:    sum = 9'd0;
      4'd2:    sum = 9'd31;
      4'd3:    sum = 9'd59;
      4'd4:    sum = 9'd90;
      4'd5:    sum = 9'd120;
      4'd6:    sum = 9'd151;
      4'd7:    sum = 9'd181;
      4'd8:    sum = 9'd212;
      4'd9:    sum = 9'd243;
      4'd10:   sum = 9'd273;
      4'd11:   sum = 9'd304;
      4'd12:   sum = 9'd334;
      default: sum = 9'd0;
    endcase
    return sum;
  endfunction

endpackage

// ----- design/gda_if.sv -----
// Valid/ready channel interfaces for requests and results of the date adder.
interface gda_req_if;
  logic                         valid;
  logic                         ready;
  logic [gda_pkg::YEAR_W-1:0]   start_year;
  logic [gda_pkg::MONTH_W-1:0]  start_month;
  logic [gda_pkg::DAY_W-1:0]    start_day;
  logic [gda_pkg::MODE_W-1:0]   mode;
  logic [gda_pkg::COUNT_W-1:0]  count;

  modport source (output valid, start_year, start_month, start_day, mode, count,
                  input ready);
  modport sink   (input valid, start_year, start_month, start_day, mode, count,
                  output ready);
endinterface

interface gda_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [gda_pkg::YEAR_W-1:0]   new_year;
  logic [gda_pkg::MONTH_W-1:0]  new_month;
  logic [gda_pkg::DAY_W-1:0]    new_day;
  logic [gda_pkg::DOY_W-1:0]    day_of_year;
  logic                         bad_date;
  logic                         year_overflow;

  modport source (output valid, new_year, new_month, new_day, day_of_year, bad_date,
                  year_overflow, input ready);
  modport sink   (input valid, new_year, new_month, new_day, day_of_year, bad_date,
                  year_overflow, output ready);
endinterface

// ----- design/gda_ctrl.sv -----
// Controller state machine: sequences load, mod-25 setup, check and stepping.
module gda_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output gda_pkg::gda_cmd_t cmd_o,
  input  gda_pkg::gda_sts_t sts_i
);

  gda_pkg::gda_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gda_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      gda_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = gda_pkg::ST_DIV;
        end
      end
      gda_pkg::ST_DIV: begin
        cmd_o.calc_q = 1'b1;
        state_d      = gda_pkg::ST_MOD;
      end
      gda_pkg::ST_MOD: begin
        cmd_o.calc_r = 1'b1;
        state_d      = gda_pkg::ST_CHECK;
      end
      gda_pkg::ST_CHECK: begin
        cmd_o.arm = 1'b1;
        if (sts_i.bad || sts_i.no_steps) begin
          state_d = gda_pkg::ST_DONE;
        end else begin
          state_d = gda_pkg::ST_RUN;
        end
      end
      gda_pkg::ST_RUN: begin
        cmd_o.step = 1'b1;
        if (sts_i.last) begin
          state_d = gda_pkg::ST_DONE;
        end
      end
      gda_pkg::ST_DONE: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = gda_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = gda_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ----- design/gda_dp.sv -----
// Datapath: date registers, year mod 25 tracking, day/month step and ordinal day.
module gda_dp (
  input  logic                         clk_i,
  input  gda_pkg::gda_cmd_t            cmd_i,
  output gda_pkg::gda_sts_t            sts_o,
  input  logic [gda_pkg::YEAR_W-1:0]   start_year_i,
  input  logic [gda_pkg::MONTH_W-1:0]  start_month_i,
  input  logic [gda_pkg::DAY_W-1:0]    start_day_i,
  input  logic [gda_pkg::MODE_W-1:0]   mode_i,
  input  logic [gda_pkg::COUNT_W-1:0]  count_i,
  output logic [gda_pkg::YEAR_W-1:0]   new_year_o,
  output logic [gda_pkg::MONTH_W-1:0]  new_month_o,
  output logic [gda_pkg::DAY_W-1:0]    new_day_o,
  output logic [gda_pkg::DOY_W-1:0]    day_of_year_o,
  output logic                         bad_date_o,
  output logic                         year_overflow_o
);

  logic [gda_pkg::YEAR_W-1:0]  y_q;
  logic [gda_pkg::MONTH_W-1:0] m_q;
  logic [gda_pkg::DAY_W-1:0]   d_q;
  logic                        ovf_q;
  logic                        bad_q;
  logic [gda_pkg::MODE_W-1:0]  mode_q;
  logic [gda_pkg::COUNT_W-1:0] count_q;
  logic [gda_pkg::QUO_W-1:0]   quo_q;
  logic [gda_pkg::M25_W-1:0]   m25_q;
  logic [gda_pkg::STEPS_W-1:0] rem_q;
  logic                        by_day_q;

  // mod 25 setup
  logic [gda_pkg::YEAR_W+gda_pkg::QUO_W-1:0] prod;
  logic [gda_pkg::YEAR_W-1:0]                q16;
  logic [gda_pkg::YEAR_W-1:0]                rdiff;
  logic [5:0]                                r6;
  logic [gda_pkg::M25_W-1:0]                 r25;

  assign prod  = (gda_pkg::YEAR_W+gda_pkg::QUO_W)'(y_q)
               * (gda_pkg::YEAR_W+gda_pkg::QUO_W)'(gda_pkg::RECIP25);
  assign q16   = gda_pkg::YEAR_W'(quo_q);
  assign rdiff = y_q - ((q16 << 4) + (q16 << 3) + q16);
  assign r6    = rdiff[5:0];
  assign r25   = (r6 >= 6'd25) ? gda_pkg::M25_W'(r6 - 6'd25) : r6[4:0];

  // step count per unit
  logic [gda_pkg::STEPS_W-1:0] c17, steps;
  logic                        by_day;

  assign c17 = gda_pkg::STEPS_W'(count_q);

  always_comb begin
    by_day = 1'b1;
    case (mode_q)
      gda_pkg::MODE_DAY:    steps = c17;
      gda_pkg::MODE_WEEK:   steps = (c17 << 3) - c17;
      gda_pkg::MODE_MONTH: begin
        steps  = c17;
        by_day = 1'b0;
      end
      gda_pkg::MODE_YEAR: begin
        steps  = (c17 << 3) + (c17 << 2);
        by_day = 1'b0;
      end
      gda_pkg::MODE_DECADE: begin
        steps  = (c17 << 7) - (c17 << 3);
        by_day = 1'b0;
      end
      default: steps = '0;
    endcase
  end

  // current date facts
  logic                      leap_cur;
  logic [gda_pkg::DAY_W-1:0] len_cur;
  logic                      at_month_end;
  logic                      is_dec;

  assign leap_cur     = gda_pkg::gda_leap(y_q, m25_q);
  assign len_cur      = gda_pkg::gda_month_len(m_q, leap_cur);
  assign at_month_end = (d_q == len_cur);
  assign is_dec       = (m_q == gda_pkg::MONTH_DEC);

  // next date
  logic                        roll_month;
  logic [gda_pkg::YEAR_W-1:0]  y_n;
  logic [gda_pkg::M25_W-1:0]   m25_n;
  logic                        ovf_n;
  logic [gda_pkg::MONTH_W-1:0] m_inc;
  logic [gda_pkg::DAY_W-1:0]   len_n;
  logic [gda_pkg::DAY_W-1:0]   d_n;

  assign roll_month = !by_day_q || at_month_end;
  assign m_inc      = is_dec ? gda_pkg::MONTH_JAN : m_q + 4'd1;

  always_comb begin
    y_n   = y_q;
    m25_n = m25_q;
    ovf_n = ovf_q;
    if (roll_month && is_dec) begin
      if (y_q == '1) begin
        y_n   = '0;
        m25_n = '0;
        ovf_n = 1'b1;
      end else begin
        y_n   = y_q + 16'd1;
        m25_n = (m25_q == gda_pkg::MOD25_TOP) ? '0 : m25_q + 5'd1;
      end
    end
  end

  assign len_n = gda_pkg::gda_month_len(m_inc, gda_pkg::gda_leap(y_n, m25_n));

  always_comb begin
    if (by_day_q) begin
      d_n = at_month_end ? 5'd1 : d_q + 5'd1;
    end else begin
      d_n = (d_q > len_n) ? len_n : d_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      y_q     <= start_year_i;
      m_q     <= start_month_i;
      d_q     <= start_day_i;
      mode_q  <= mode_i;
      count_q <= count_i;
      ovf_q   <= 1'b0;
    end
    if (cmd_i.calc_q) begin
      quo_q <= prod[gda_pkg::YEAR_W +: gda_pkg::QUO_W];
    end
    if (cmd_i.calc_r) begin
      m25_q <= r25;
    end
    if (cmd_i.arm) begin
      bad_q    <= sts_o.bad;
      rem_q    <= steps;
      by_day_q <= by_day;
    end
    if (cmd_i.step) begin
      y_q   <= y_n;
      m25_q <= m25_n;
      ovf_q <= ovf_n;
      m_q   <= roll_month ? m_inc : m_q;
      d_q   <= d_n;
      rem_q <= rem_q - 17'd1;
    end
  end

  assign sts_o.bad      = (m_q == '0) || (m_q > gda_pkg::MONTH_DEC) || (d_q == '0)
                        || (d_q > len_cur);
  assign sts_o.no_steps = (steps == '0);
  assign sts_o.last     = (rem_q == 17'd1);

  assign new_year_o      = y_q;
  assign new_month_o     = m_q;
  assign new_day_o       = d_q;
  assign bad_date_o      = bad_q;
  assign year_overflow_o = ovf_q && !bad_q;
  assign day_of_year_o   = bad_q ? '0
                         : gda_pkg::gda_days_before(m_q) + gda_pkg::DOY_W'(d_q)
                           + gda_pkg::DOY_W'(leap_cur && (m_q > gda_pkg::MONTH_FEB));

endmodule

// ----- design/gregorian_date_adder_top.sv -----
// Top level of the Gregorian date adder: controller plus datapath.
// Sequence: the request is loaded, then the year/25 estimate, year mod 25 and the date check are
// registered, then the run state steps; steps are count for day and month, 7*count for week,
// 12*count for year, 120*count for decade, done by the single day/month step unit.
// Throughput: one request at a time; the next is taken once the result is taken.
// Reset: rst_ni clears the controller to idle with no result pending.
module gregorian_date_adder_top (
  input  logic     clk_i,
  input  logic     rst_ni,
  gda_req_if.sink  req_i,
  gda_rsp_if.source rsp_o
);

  gda_pkg::gda_cmd_t cmd;
  gda_pkg::gda_sts_t sts;

  gda_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  gda_dp u_dp (
    .clk_i           (clk_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .start_year_i    (req_i.start_year),
    .start_month_i   (req_i.start_month),
    .start_day_i     (req_i.start_day),
    .mode_i          (req_i.mode),
    .count_i         (req_i.count),
    .new_year_o      (rsp_o.new_year),
    .new_month_o     (rsp_o.new_month),
    .new_day_o       (rsp_o.new_day),
    .day_of_year_o   (rsp_o.day_of_year),
    .bad_date_o      (rsp_o.bad_date),
    .year_overflow_o (rsp_o.year_overflow)
  );

endmodule

// ----- design/gda_checker.sv -----
// Port-level assertions for the date adder, bound to the top level.
module gda_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_i,
  input logic                         out_valid_i,
  input logic                         out_ready_i,
  input logic [gda_pkg::YEAR_W-1:0]   new_year_i,
  input logic [gda_pkg::MONTH_W-1:0]  new_month_i,
  input logic [gda_pkg::DAY_W-1:0]    new_day_i,
  input logic [gda_pkg::DOY_W-1:0]    day_of_year_i,
  input logic                         bad_date_i,
  input logic                         year_overflow_i
);

  // one request in flight: no new request while a result is pending
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !in_ready_i)
    else $error("request taken while result pending");

  a_not_instant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !out_valid_i)
    else $error("result shown right after request");

  a_bad_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && bad_date_i) |-> (day_of_year_i == '0) && !year_overflow_i)
    else $error("bad date result carries ordinal or overflow");

  a_good_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !bad_date_i) |-> (new_month_i != '0) && (new_month_i <= 4'd12)
      && (new_day_i != '0) && (day_of_year_i != '0) && (day_of_year_i <= 9'd366))
    else $error("valid result out of calendar range");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> out_valid_i && $stable(new_year_i)
      && $stable(new_month_i) && $stable(new_day_i) && $stable(day_of_year_i))
    else $error("stalled result changed");

endmodule

bind gregorian_date_adder_top gda_checker u_gda_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (req_i.valid),
  .in_ready_i      (req_i.ready),
  .out_valid_i     (rsp_o.valid),
  .out_ready_i     (rsp_o.ready),
  .new_year_i      (rsp_o.new_year),
  .new_month_i     (rsp_o.new_month),
  .new_day_i       (rsp_o.new_day),
  .day_of_year_i   (rsp_o.day_of_year),
  .bad_date_i      (rsp_o.bad_date),
  .year_overflow_i (rsp_o.year_overflow)
);

// ----- verif/gregorian_date_adder_top_test.sv -----
// Self-checking testbench for the Gregorian date adder: directed table, then random requests.
module gregorian_date_adder_top_test;
  import gda_pkg::*;

  localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd5;
  localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;
  localparam int unsigned YEAR_TOP      = 65535;
  localparam int unsigned STALL_LIMIT   = 500000;
  localparam int unsigned SETTLE_CYCLES = 10;
  localparam bit TYPED   = 1'b1;
  localparam bit PREDICT = 1'b0;

  typedef struct packed {
    logic [YEAR_W-1:0]  start_year;
    logic [MONTH_W-1:0] start_month;
    logic [DAY_W-1:0]   start_day;
    logic [MODE_W-1:0]  mode;
    logic [COUNT_W-1:0] count;
  } date_req_t;

  typedef struct packed {
    logic [YEAR_W-1:0]  new_year;
    logic [MONTH_W-1:0] new_month;
    logic [DAY_W-1:0]   new_day;
    logic [DOY_W-1:0]   day_of_year;
    logic               bad_date;
    logic               year_overflow;
  } date_rsp_t;

  typedef struct packed {
    logic      typed;
    date_req_t req;
    date_rsp_t rsp;
  } plan_row_t;

  localparam date_rsp_t NO_RSP = '0;
  localparam int unsigned PLAN_LEN = 25;

  // rows marked PREDICT take their expectation from advance_date
  localparam plan_row_t PLAN [0:PLAN_LEN-1] = '{
    {TYPED, 16'd2024, 4'd1, 5'd1, MODE_DAY, 10'd0, 16'd2024, 4'd1, 5'd1, 9'd1, 1'b0, 1'b0},
    {TYPED, 16'd2023, 4'd12, 5'd31, MODE_DAY, 10'd1, 16'd2024, 4'd1, 5'd1, 9'd1, 1'b0, 1'b0},
    {TYPED, 16'd2024, 4'd2, 5'd28, MODE_DAY, 10'd1, 16'd2024, 4'd2, 5'd29, 9'd60, 1'b0, 1'b0},
    {TYPED, 16'd2023, 4'd2, 5'd28, MODE_DAY, 10'd1, 16'd2023, 4'd3, 5'd1, 9'd60, 1'b0, 1'b0},
    {TYPED, 16'd65535, 4'd12, 5'd31, MODE_DAY, 10'd1, 16'd0, 4'd1, 5'd1, 9'd1, 1'b0, 1'b1},
    {TYPED, 16'd2000, 4'd0, 5'd1, MODE_DAY, 10'd5, 16'd2000, 4'd0, 5'd1, 9'd0, 1'b1, 1'b0},
    {TYPED, 16'd65535, 4'd15, 5'd31, MODE_SPARE_HI, 10'd1023,
     16'd65535, 4'd15, 5'd31, 9'd0, 1'b1, 1'b0},
    {TYPED, 16'd1999, 4'd5, 5'd0, MODE_DAY, 10'd3, 16'd1999, 4'd5, 5'd0, 9'd0, 1'b1, 1'b0},
    {TYPED, 16'd2023, 4'd2, 5'd29, MODE_WEEK, 10'd2, 16'd2023, 4'd2, 5'd29, 9'd0, 1'b1, 1'b0},
    {TYPED, 16'd1900, 4'd2, 5'd29, MODE_MONTH, 10'd1, 16'd1900, 4'd2, 5'd29, 9'd0, 1'b1, 1'b0},
    {TYPED, 16'd2000, 4'd2, 5'd29, MODE_YEAR, 10'd1, 16'd2001, 4'd2, 5'd28, 9'd59, 1'b0, 1'b0},
    {TYPED, 16'd2024, 4'd1, 5'd31, MODE_MONTH, 10'd1, 16'd2024, 4'd2, 5'd29, 9'd60, 1'b0, 1'b0},
    {TYPED, 16'd2024, 4'd1, 5'd31, MODE_MONTH, 10'd2, 16'd2024, 4'd3, 5'd29, 9'd89, 1'b0, 1'b0},
    {TYPED, 16'd2023, 4'd4, 5'd31, MODE_DECADE, 10'd1,
     16'd2023, 4'd4, 5'd31, 9'd0, 1'b1, 1'b0},
    {TYPED, 16'd0, 4'd13, 5'd15, MODE_MONTH, 10'd1, 16'd0, 4'd13, 5'd15, 9'd0, 1'b1, 1'b0},
    {PREDICT, 16'd2023, 4'd6, 5'd15, MODE_SPARE_LO, 10'd100, NO_RSP},
    {PREDICT, 16'd2023, 4'd6, 5'd15, 3'd6, 10'd0, NO_RSP},
    {PREDICT, 16'd2024, 4'd12, 5'd25, MODE_WEEK, 10'd1, NO_RSP},
    {PREDICT, 16'd2024, 4'd3, 5'd15, MODE_DECADE, 10'd1023, NO_RSP},
    {PREDICT, 16'd65000, 4'd6, 5'd30, MODE_YEAR, 10'd1023, NO_RSP},
    {PREDICT, 16'd2023, 4'd1, 5'd1, MODE_DAY, 10'd1023, NO_RSP},
    {PREDICT, 16'd2023, 4'd12, 5'd31, MODE_MONTH, 10'd1, NO_RSP},
    {PREDICT, 16'd0, 4'd2, 5'd29, MODE_DAY, 10'd1, NO_RSP},
    {PREDICT, 16'd65535, 4'd12, 5'd15, MODE_DECADE, 10'd1, NO_RSP},
    {PREDICT, 16'd2100, 4'd2, 5'd28, MODE_DAY, 10'd1, NO_RSP}
  };

  logic clk_i;
  logic rst_ni;

  gda_req_if req_bus ();
  gda_rsp_if rsp_bus ();

  gregorian_date_adder_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_bus),
    .rsp_o  (rsp_bus)
  );

  date_rsp_t   pending_dates [$];
  date_rsp_t   oldest_date;
  int unsigned mismatch_count = 0;
  int unsigned stall_cycles   = 0;
  int unsigned send_gap_pct   = 34;
  int unsigned take_gap_pct   = 49;

  function automatic int unsigned month_days(int unsigned y, int unsigned m);
    bit leap;
    leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    if (m < 1 || m > 12) return 0;
    if (m == 2) return leap ? 29 : 28;
    if (m == 4 || m == 6 || m == 9 || m == 11) return 30;
    return 31;
  endfunction

  function automatic date_rsp_t advance_date(date_req_t r);
    date_rsp_t   res;
    int unsigned y, m, d, steps, k, doy;
    bit          by_month, wrapped;
    y = r.start_year;
    m = r.start_month;
    d = r.start_day;
    by_month = 1'b0;
    wrapped  = 1'b0;
    res.new_year  = r.start_year;
    res.new_month = r.start_month;
    res.new_day   = r.start_day;
    if (m < 1 || m > 12 || d < 1 || d > month_days(y, m)) begin
      res.day_of_year   = '0;
      res.bad_date      = 1'b1;
      res.year_overflow = 1'b0;
      return res;
    end
    case (r.mode)
      MODE_DAY:    steps = int'(r.count);
      MODE_WEEK:   steps = int'(r.count) * 7;
      MODE_MONTH:  begin steps = int'(r.count);       by_month = 1'b1; end
      MODE_YEAR:   begin steps = int'(r.count) * 12;  by_month = 1'b1; end
      MODE_DECADE: begin steps = int'(r.count) * 120; by_month = 1'b1; end
      default:     steps = 0;
    endcase
    for (k = 0; k < steps; k++) begin
      if (!by_month && d < month_days(y, m)) begin
        d++;
      end else begin
        if (!by_month) d = 1;
        if (m == 12) begin
          m = 1;
          if (y == YEAR_TOP) begin
            y = 0;
            wrapped = 1'b1;
          end else begin
            y++;
          end
        end else begin
          m++;
        end
        // month steps clamp to the new month's leap-aware length
        if (by_month && d > month_days(y, m)) d = month_days(y, m);
      end
    end
    doy = d;
    for (k = 1; k < m; k++) doy += month_days(y, k);
    res.new_year      = y[YEAR_W-1:0];
    res.new_month     = m[MONTH_W-1:0];
    res.new_day       = d[DAY_W-1:0];
    res.day_of_year   = doy[DOY_W-1:0];
    res.bad_date      = 1'b0;
    res.year_overflow = wrapped;
    return res;
  endfunction

  // Mostly valid dates with small counts; bad dates and spare modes carry any count.
  function automatic date_req_t pick_date_request();
    date_req_t   r;
    int unsigned kind, sel, y, m, len;
    kind = $urandom_range(99);
    sel  = $urandom_range(9);
    if (sel < 2)      y = YEAR_TOP - $urandom_range(0, 40);
    else if (sel < 3) y = $urandom_range(0, 40);
    else if (sel < 5) y = $urandom_range(1, 655) * 100 - 4 + $urandom_range(0, 8);
    else              y = $urandom_range(0, YEAR_TOP);
    m   = $urandom_range(1, 12);
    len = month_days(y, m);
    r.start_year  = y[YEAR_W-1:0];
    r.start_month = m[MONTH_W-1:0];
    if ($urandom_range(3) == 0) r.start_day = DAY_W'(len - $urandom_range(0, 1));
    else                        r.start_day = DAY_W'($urandom_range(1, len));
    if (kind < 8) begin
      case ($urandom_range(3))
        0: begin
          r.start_month = '0;
          r.start_day   = DAY_W'($urandom_range(0, 31));
        end
        1: begin
          r.start_month = MONTH_W'($urandom_range(13, 15));
          r.start_day   = DAY_W'($urandom_range(0, 31));
        end
        2: r.start_day = '0;
        default: r.start_day = (len < 31) ? DAY_W'($urandom_range(len + 1, 31)) : '0;
      endcase
      r.mode  = MODE_W'($urandom_range(0, 7));
      r.count = COUNT_W'($urandom_range(0, 1023));
    end else if (kind < 14) begin
      r.mode  = MODE_W'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
      r.count = COUNT_W'($urandom_range(0, 1023));
    end else begin
      r.mode = MODE_W'($urandom_range(MODE_DAY, MODE_DECADE));
      case (r.mode)
        MODE_DAY:
          r.count = ($urandom_range(4) == 0) ? COUNT_W'($urandom_range(0, 1023))
                                             : COUNT_W'($urandom_range(0, 40));
        MODE_WEEK:
          r.count = ($urandom_range(7) == 0) ? COUNT_W'($urandom_range(0, 146))
                                             : COUNT_W'($urandom_range(0, 20));
        MODE_MONTH:
          r.count = ($urandom_range(9) == 0) ? COUNT_W'($urandom_range(0, 1023))
                                             : COUNT_W'($urandom_range(0, 40));
        MODE_YEAR:
          r.count = ($urandom_range(9) == 0) ? COUNT_W'($urandom_range(0, 80))
                                             : COUNT_W'($urandom_range(0, 10));
        default:
          r.count = ($urandom_range(19) == 0) ? COUNT_W'($urandom_range(0, 12))
                                              : COUNT_W'($urandom_range(0, 3));
      endcase
    end
    return r;
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Present one request from a falling edge; queue its expectation once accepted.
  task automatic send_request(input date_req_t r, input date_rsp_t want);
    @(negedge clk_i);
    while ($urandom_range(99) < send_gap_pct) begin
      req_bus.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_bus.valid       <= 1'b1;
    req_bus.start_year  <= r.start_year;
    req_bus.start_month <= r.start_month;
    req_bus.start_day   <= r.start_day;
    req_bus.mode        <= r.mode;
    req_bus.count       <= r.count;
    @(posedge clk_i);
    while (!req_bus.ready) @(posedge clk_i);
    pending_dates.push_back(want);
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    req_bus.valid <= 1'b0;
    while (pending_dates.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    rsp_bus.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      rsp_bus.ready <= ($urandom_range(99) >= take_gap_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
        stall_cycles <= 0;
      else
        stall_cycles <= stall_cycles + 1;
      if (rsp_bus.valid && rsp_bus.ready) begin
        if (pending_dates.size() == 0) begin
          flag_mismatch($sformatf("result %0d-%0d-%0d with no request pending",
                                  rsp_bus.new_year, rsp_bus.new_month, rsp_bus.new_day));
        end else begin
          oldest_date = pending_dates.pop_front();
          if (rsp_bus.new_year !== oldest_date.new_year)
            flag_mismatch($sformatf("new_year got %0d expected %0d",
                                    rsp_bus.new_year, oldest_date.new_year));
          if (rsp_bus.new_month !== oldest_date.new_month)
            flag_mismatch($sformatf("new_month got %0d expected %0d",
                                    rsp_bus.new_month, oldest_date.new_month));
          if (rsp_bus.new_day !== oldest_date.new_day)
            flag_mismatch($sformatf("new_day got %0d expected %0d",
                                    rsp_bus.new_day, oldest_date.new_day));
          if (rsp_bus.day_of_year !== oldest_date.day_of_year)
            flag_mismatch($sformatf("day_of_year got %0d expected %0d",
                                    rsp_bus.day_of_year, oldest_date.day_of_year));
          if (rsp_bus.bad_date !== oldest_date.bad_date)
            flag_mismatch($sformatf("bad_date got %0b expected %0b",
                                    rsp_bus.bad_date, oldest_date.bad_date));
          if (rsp_bus.year_overflow !== oldest_date.year_overflow)
            flag_mismatch($sformatf("year_overflow got %0b expected %0b",
                                    rsp_bus.year_overflow, oldest_date.year_overflow));
        end
      end
    end
  end

  // watchdog: too long with no request and no result taken
  initial begin
    while (stall_cycles < STALL_LIMIT) @(posedge clk_i);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    plan_row_t   row;
    date_req_t   r;
    int unsigned i;
    rst_ni              = 1'b0;
    req_bus.valid       = 1'b0;
    req_bus.start_year  = '0;
    req_bus.start_month = '0;
    req_bus.start_day   = '0;
    req_bus.mode        = '0;
    req_bus.count       = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (i = 0; i < PLAN_LEN; i++) begin
      row = PLAN[i];
      send_request(row.req, row.typed ? row.rsp : advance_date(row.req));
    end
    drain_results();

    for (i = 0; i < 200; i++) begin
      r = pick_date_request();
      send_request(r, advance_date(r));
    end
    drain_results();

    send_gap_pct = 49;
    take_gap_pct = 34;
    for (i = 0; i < 190; i++) begin
      r = pick_date_request();
      send_request(r, advance_date(r));
    end
    drain_results();

    send_gap_pct = 0;
    take_gap_pct = 0;
    for (i = 0; i < 190; i++) begin
      r = pick_date_request();
      send_request(r, advance_date(r));
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
